@@ design/amp_pkg.sv @@
`default_nettype none

package amp_pkg;

    localparam int SAMPLE_WIDTH_DEF  = 14;
    localparam int CORDIC_STAGES_DEF = 16;

    // full-scale register
    localparam int             FS_W     = 13;
    localparam logic [FS_W-1:0] FS_RESET = 13'd2000;

    // counts that stand for full scale, and rounding of the magnitude root
    localparam int COUNTS_FULL = 8192;
    localparam int MAG_SHIFT   = $clog2(2 * COUNTS_FULL);

    // cordic operands are counts scaled by 2^OPERAND_SHIFT
    localparam int OPERAND_SHIFT = 12;

    // result field widths
    localparam int MAG_W   = 14;
    localparam int PITCH_W = 11;
    localparam int ROLL_W  = 12;
    localparam int MAG_MAX = (1 << MAG_W) - 1;

    // angle accumulator in 2^-16 tenth-degree
    localparam int ACC_W      = 32;
    localparam int ANGLE_FRAC = 16;
    localparam int ANG_W      = ACC_W - ANGLE_FRAC;
    localparam int ATAN_LEN   = 24;

    localparam logic signed [ACC_W-1:0] QUARTER_TURN = 32'sd58982400;
    localparam logic signed [ACC_W-1:0] ROUND_HALF   = 32'sd32768;

    localparam logic signed [ANG_W-1:0] DEG90     = 16'sd900;
    localparam logic signed [ANG_W-1:0] DEG180    = 16'sd1800;
    localparam logic signed [ANG_W-1:0] PITCH_LIM = 16'sd900;
    localparam logic signed [ANG_W-1:0] ROLL_LIM  = 16'sd1800;

    // atan(2^-i) in 2^-16 tenth-degree
    function automatic logic signed [ACC_W-1:0] atan_entry(input int idx);
        logic signed [ACC_W-1:0] v;
        case (idx)
            0:       v = 32'sd29491200;
            1:       v = 32'sd17409672;
            2:       v = 32'sd9198793;
            3:       v = 32'sd4669451;
            4:       v = 32'sd2343786;
            5:       v = 32'sd1173036;
            6:       v = 32'sd586661;
            7:       v = 32'sd293348;
            8:       v = 32'sd146676;
            9:       v = 32'sd73339;
            10:      v = 32'sd36669;
            11:      v = 32'sd18335;
            12:      v = 32'sd9167;
            13:      v = 32'sd4584;
            14:      v = 32'sd2292;
            15:      v = 32'sd1146;
            16:      v = 32'sd573;
            17:      v = 32'sd286;
            18:      v = 32'sd143;
            19:      v = 32'sd72;
            20:      v = 32'sd36;
            21:      v = 32'sd18;
            22:      v = 32'sd9;
            23:      v = 32'sd4;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

@@ design/amp_ifs.sv @@
`default_nettype none

interface amp_sample_if import amp_pkg::*; #(parameter int W = SAMPLE_WIDTH_DEF);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] accel_x;
    logic signed [W-1:0] accel_y;
    logic signed [W-1:0] accel_z;

    modport source (output valid, output accel_x, output accel_y, output accel_z,
                    input ready);
    modport sink   (input valid, input accel_x, input accel_y, input accel_z,
                    output ready);
endinterface

interface amp_result_if import amp_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic        [MAG_W-1:0]   magnitude_mg;
    logic signed [PITCH_W-1:0] pitch_decideg;
    logic signed [ROLL_W-1:0]  roll_decideg;

    modport source (output valid, output magnitude_mg, output pitch_decideg,
                    output roll_decideg, input ready);
    modport sink   (input valid, input magnitude_mg, input pitch_decideg,
                    input roll_decideg, output ready);
endinterface

interface amp_cfg_if import amp_pkg::*;;
    logic            valid;
    logic            ready;
    logic [FS_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ design/amp_isqrt2.sv @@
`default_nettype none

// two-lane pipelined integer square root, one result bit per stage
module amp_isqrt2 #(
    parameter int RAD_W = 58,
    parameter int SBW   = 42,
    localparam int ROOT_W = RAD_W / 2
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output      logic              in_ready,
    input  wire logic [RAD_W-1:0]  rad_a,
    input  wire logic [RAD_W-1:0]  rad_b,
    input  wire logic [SBW-1:0]    sb_in,
    output      logic              out_valid,
    input  wire logic              out_ready,
    output      logic [ROOT_W-1:0] root_a,
    output      logic [ROOT_W-1:0] root_b,
    output      logic [SBW-1:0]    sb_out
);

    localparam int N     = ROOT_W;
    localparam int REM_W = ROOT_W + 3;

    logic              valid_reg [0:N-1];
    logic              stage_en  [0:N];
    logic [SBW-1:0]    sb_reg    [0:N-1];
    logic [REM_W-1:0]  rem_reg   [0:N-1][0:1];
    logic [ROOT_W-1:0] root_reg  [0:N-1][0:1];
    logic [RAD_W-1:0]  rad_reg   [0:N-1][0:1];

    assign stage_en[N] = out_ready;

    for (genvar k = 0; k < N; k++)
    begin : g_stage
        logic           prev_valid;
        logic [SBW-1:0] prev_sb;

        assign stage_en[k] = !valid_reg[k] || stage_en[k+1];

        if (k == 0)
        begin : g_head
            assign prev_valid = in_valid;
            assign prev_sb    = sb_in;
        end
        else
        begin : g_body
            assign prev_valid = valid_reg[k-1];
            assign prev_sb    = sb_reg[k-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (stage_en[k])
                valid_reg[k] <= prev_valid;
        end

        always_ff @(posedge clk)
        begin
            if (stage_en[k])
                sb_reg[k] <= prev_sb;
        end

        for (genvar l = 0; l < 2; l++)
        begin : g_lane
            logic [REM_W-1:0]  rem_prev;
            logic [REM_W-1:0]  rem_shift;
            logic [REM_W-1:0]  trial;
            logic [REM_W-1:0]  rem_next;
            logic [ROOT_W-1:0] root_prev;
            logic [ROOT_W-1:0] root_next;
            logic [RAD_W-1:0]  rad_prev;

            if (k == 0)
            begin : g_head
                assign rem_prev  = '0;
                assign root_prev = '0;
                assign rad_prev  = (l == 0) ? rad_a : rad_b;
            end
            else
            begin : g_body
                assign rem_prev  = rem_reg[k-1][l];
                assign root_prev = root_reg[k-1][l];
                assign rad_prev  = rad_reg[k-1][l];
            end

            always_comb
            begin
                rem_shift = {rem_prev[REM_W-3:0], rad_prev[RAD_W-1 -: 2]};
                trial     = REM_W'({root_prev, 2'b01});
                if (rem_shift >= trial)
                begin
                    rem_next  = rem_shift - trial;
                    root_next = {root_prev[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_shift;
                    root_next = {root_prev[ROOT_W-2:0], 1'b0};
                end
            end

            always_ff @(posedge clk)
            begin
                if (stage_en[k])
                begin
                    rem_reg[k][l]  <= rem_next;
                    root_reg[k][l] <= root_next;
                    rad_reg[k][l]  <= {rad_prev[RAD_W-3:0], 2'b00};
                end
            end
        end
    end

    assign in_ready  = stage_en[0];
    assign out_valid = valid_reg[N-1];
    assign root_a    = root_reg[N-1][0];
    assign root_b    = root_reg[N-1][1];
    assign sb_out    = sb_reg[N-1];

endmodule

`default_nettype wire

@@ design/amp_cordic.sv @@
`default_nettype none

// two-lane pipelined vectoring cordic, atan2(y, x) in tenths of a degree
module amp_cordic import amp_pkg::*; #(
    parameter int CW     = 29,
    parameter int STAGES = CORDIC_STAGES_DEF,
    parameter int SBW    = MAG_W
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output      logic                    in_ready,
    input  wire logic signed [CW-1:0]    vec_x [0:1],
    input  wire logic signed [CW-1:0]    vec_y [0:1],
    input  wire logic        [SBW-1:0]   sb_in,
    output      logic                    out_valid,
    input  wire logic                    out_ready,
    output      logic signed [ANG_W-1:0] angle [0:1],
    output      logic        [SBW-1:0]   sb_out
);

    // stage 0 pre-rotation, 1..STAGES micro-rotations, last one rounding
    localparam int N = STAGES + 2;

    logic                    valid_reg   [0:N-1];
    logic                    stage_en    [0:N];
    logic        [SBW-1:0]   sb_reg      [0:N-1];
    logic signed [CW-1:0]    x_reg       [0:STAGES][0:1];
    logic signed [CW-1:0]    y_reg       [0:STAGES][0:1];
    logic signed [ACC_W-1:0] acc_reg     [0:STAGES][0:1];
    logic                    special_reg [0:STAGES][0:1];
    logic signed [ANG_W-1:0] spec_reg    [0:STAGES][0:1];
    logic signed [ANG_W-1:0] angle_reg   [0:1];

    assign stage_en[N] = out_ready;

    for (genvar k = 0; k < N; k++)
    begin : g_ctrl
        logic           prev_valid;
        logic [SBW-1:0] prev_sb;

        assign stage_en[k] = !valid_reg[k] || stage_en[k+1];

        if (k == 0)
        begin : g_head
            assign prev_valid = in_valid;
            assign prev_sb    = sb_in;
        end
        else
        begin : g_body
            assign prev_valid = valid_reg[k-1];
            assign prev_sb    = sb_reg[k-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (stage_en[k])
                valid_reg[k] <= prev_valid;
        end

        always_ff @(posedge clk)
        begin
            if (stage_en[k])
                sb_reg[k] <= prev_sb;
        end
    end

    for (genvar l = 0; l < 2; l++)
    begin : g_lane
        logic signed [CW-1:0]    x_next;
        logic signed [CW-1:0]    y_next;
        logic signed [ACC_W-1:0] acc_next;
        logic                    special_next;
        logic signed [ANG_W-1:0] spec_next;
        logic signed [ACC_W-1:0] round_sum;
        logic signed [ANG_W-1:0] angle_next;

        // axis cases and left half-plane folding
        always_comb
        begin
            x_next       = vec_x[l];
            y_next       = vec_y[l];
            acc_next     = '0;
            special_next = 1'b0;
            spec_next    = '0;
            if (vec_x[l] == '0)
            begin
                special_next = 1'b1;
                if (vec_y[l] > 0)
                    spec_next = DEG90;
                else if (vec_y[l] < 0)
                    spec_next = -DEG90;
            end
            else if (vec_y[l] == '0)
            begin
                special_next = 1'b1;
                if (vec_x[l] < 0)
                    spec_next = DEG180;
            end
            else if (vec_x[l] < 0)
            begin
                if (vec_y[l] > 0)
                begin
                    x_next   = vec_y[l];
                    y_next   = -vec_x[l];
                    acc_next = QUARTER_TURN;
                end
                else
                begin
                    x_next   = -vec_y[l];
                    y_next   = vec_x[l];
                    acc_next = -QUARTER_TURN;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (stage_en[0])
            begin
                x_reg[0][l]       <= x_next;
                y_reg[0][l]       <= y_next;
                acc_reg[0][l]     <= acc_next;
                special_reg[0][l] <= special_next;
                spec_reg[0][l]    <= spec_next;
            end
        end

        for (genvar i = 0; i < STAGES; i++)
        begin : g_iter
            logic signed [CW-1:0]    dx;
            logic signed [CW-1:0]    dy;
            logic signed [CW-1:0]    xi_next;
            logic signed [CW-1:0]    yi_next;
            logic signed [ACC_W-1:0] acci_next;

            always_comb
            begin
                dx = y_reg[i][l] >>> i;
                dy = x_reg[i][l] >>> i;
                if (y_reg[i][l] > 0)
                begin
                    xi_next   = x_reg[i][l] + dx;
                    yi_next   = y_reg[i][l] - dy;
                    acci_next = acc_reg[i][l] + atan_entry(i);
                end
                else
                begin
                    xi_next   = x_reg[i][l] - dx;
                    yi_next   = y_reg[i][l] + dy;
                    acci_next = acc_reg[i][l] - atan_entry(i);
                end
            end

            always_ff @(posedge clk)
            begin
                if (stage_en[i+1])
                begin
                    x_reg[i+1][l]       <= xi_next;
                    y_reg[i+1][l]       <= yi_next;
                    acc_reg[i+1][l]     <= acci_next;
                    special_reg[i+1][l] <= special_reg[i][l];
                    spec_reg[i+1][l]    <= spec_reg[i][l];
                end
            end
        end

        // half a tenth-degree rounds up
        always_comb
        begin
            round_sum  = acc_reg[STAGES][l] + ROUND_HALF;
            angle_next = special_reg[STAGES][l] ? spec_reg[STAGES][l]
                                                : round_sum[ACC_W-1:ANGLE_FRAC];
        end

        always_ff @(posedge clk)
        begin
            if (stage_en[N-1])
                angle_reg[l] <= angle_next;
        end

        assign angle[l] = angle_reg[l];
    end

    assign in_ready  = stage_en[0];
    assign out_valid = valid_reg[N-1];
    assign sb_out    = sb_reg[N-1];

endmodule

`default_nettype wire

@@ design/accel_magnitude_pitch_roll.sv @@
`default_nettype none

// channel   dir  beat payload
// sample    in   accel_x, accel_y, accel_z (signed counts)
// result    out  magnitude_mg, pitch_decideg, roll_decideg
// cfg       in   full_scale_mg (13 bits), always ready
//
// one beat per cycle sustained while result is not stalled; a beat passes the front
// stages, the bit-per-stage root, the cordic stages and the output register in order.
// rst_n is asynchronous and clears every valid bit and full_scale_mg to 2000
// each stage holds while it is full and its successor holds, so a stall on result backs up
// only as far as the pipeline is occupied; nothing is dropped or repeated
module accel_magnitude_pitch_roll import amp_pkg::*; #(
    parameter int SAMPLE_WIDTH  = SAMPLE_WIDTH_DEF,
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input wire logic     clk,
    input wire logic     rst_n,
    amp_sample_if.sink   sample,
    amp_result_if.source result,
    amp_cfg_if.sink      cfg
);

    localparam int SW     = SAMPLE_WIDTH;
    localparam int SQ_W   = 2 * SW - 1;        // one square
    localparam int S_W    = 2 * SW + 1;        // sum of three squares
    localparam int SYZ_W  = 2 * SW;            // sum of two squares
    localparam int FS2_W  = 2 * FS_W;
    localparam int T_W    = S_W + FS2_W;
    localparam int RAD_W  = ((T_W + 3) / 2) * 2;
    localparam int ROOT_W = RAD_W / 2;
    localparam int CW     = SW + OPERAND_SHIFT + 3;
    localparam int SBW    = 3 * SW;

    // full-scale register and its square
    logic [FS_W-1:0]  fs_reg;
    logic [FS2_W-1:0] fs_sq_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fs_reg    <= FS_RESET;
            fs_sq_reg <= FS2_W'(FS_RESET * FS_RESET);
        end
        else
        begin
            if (cfg.valid)
                fs_reg <= cfg.data;
            fs_sq_reg <= FS2_W'(fs_reg * fs_reg);
        end
    end

    // front stages: squares, sums, scaling product
    logic v1_reg, v2_reg, v3_reg;
    logic en1, en2, en3;
    logic isq_in_ready;

    logic signed [SW-1:0] x1_reg, y1_reg, z1_reg;
    logic signed [SW-1:0] x2_reg, y2_reg, z2_reg;
    logic signed [SW-1:0] x3_reg, y3_reg, z3_reg;
    logic [SQ_W-1:0]      xx_reg, yy_reg, zz_reg;
    logic [S_W-1:0]       s_reg;
    logic [SYZ_W-1:0]     syz_reg;
    logic [RAD_W-1:0]     mag_rad_reg, h_rad_reg;

    logic signed [2*SW-1:0] xx_full, yy_full, zz_full;
    logic [T_W-1:0]         prod_next;

    assign en1 = !v1_reg || en2;
    assign en2 = !v2_reg || en3;
    assign en3 = !v3_reg || isq_in_ready;
    assign sample.ready = en1;

    always_comb
    begin
        xx_full   = sample.accel_x * sample.accel_x;
        yy_full   = sample.accel_y * sample.accel_y;
        zz_full   = sample.accel_z * sample.accel_z;
        prod_next = T_W'(s_reg) * T_W'(fs_sq_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= sample.valid;
            if (en2)
                v2_reg <= v1_reg;
            if (en3)
                v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            x1_reg <= sample.accel_x;
            y1_reg <= sample.accel_y;
            z1_reg <= sample.accel_z;
            xx_reg <= xx_full[SQ_W-1:0];
            yy_reg <= yy_full[SQ_W-1:0];
            zz_reg <= zz_full[SQ_W-1:0];
        end
        if (en2)
        begin
            x2_reg  <= x1_reg;
            y2_reg  <= y1_reg;
            z2_reg  <= z1_reg;
            s_reg   <= S_W'(xx_reg) + S_W'(yy_reg) + S_W'(zz_reg);
            syz_reg <= SYZ_W'(yy_reg) + SYZ_W'(zz_reg);
        end
        if (en3)
        begin
            x3_reg      <= x2_reg;
            y3_reg      <= y2_reg;
            z3_reg      <= z2_reg;
            // 4 * s * fs^2 for the magnitude, (y^2 + z^2) * 2^24 for the pitch base
            mag_rad_reg <= RAD_W'(prod_next) << 2;
            h_rad_reg   <= RAD_W'(syz_reg) << (2 * OPERAND_SHIFT);
        end
    end

    // both square roots side by side, raw sample riding along
    logic              isq_out_valid;
    logic              cor_in_ready;
    logic [ROOT_W-1:0] mag_root, h_root;
    logic [SBW-1:0]    isq_sb;

    amp_isqrt2 #(
        .RAD_W (RAD_W),
        .SBW   (SBW)
    ) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v3_reg),
        .in_ready  (isq_in_ready),
        .rad_a     (mag_rad_reg),
        .rad_b     (h_rad_reg),
        .sb_in     ({x3_reg, y3_reg, z3_reg}),
        .out_valid (isq_out_valid),
        .out_ready (cor_in_ready),
        .root_a    (mag_root),
        .root_b    (h_root),
        .sb_out    (isq_sb)
    );

    // magnitude rounding and saturation, cordic operands
    logic [ROOT_W:0]      mag_sum, mag_shifted;
    logic [MAG_W-1:0]     mag_next;
    logic signed [SW-1:0] xs, ys, zs;
    logic signed [CW-1:0] xe, ye, ze;
    logic signed [CW-1:0] op_x [0:1];
    logic signed [CW-1:0] op_y [0:1];

    always_comb
    begin
        mag_sum     = (ROOT_W + 1)'(mag_root) + (ROOT_W + 1)'(COUNTS_FULL);
        mag_shifted = mag_sum >> MAG_SHIFT;
        if (mag_shifted > (ROOT_W + 1)'(MAG_MAX))
            mag_next = MAG_W'(MAG_MAX);
        else
            mag_next = MAG_W'(mag_shifted);

        xs = isq_sb[3*SW-1:2*SW];
        ys = isq_sb[2*SW-1:SW];
        zs = isq_sb[SW-1:0];
        xe = CW'(xs);
        ye = CW'(ys);
        ze = CW'(zs);

        // lane 0 pitch: atan2(-x, h); lane 1 roll: atan2(y, z)
        op_x[0] = $signed(CW'(h_root));
        op_y[0] = -(xe <<< OPERAND_SHIFT);
        op_x[1] = ze <<< OPERAND_SHIFT;
        op_y[1] = ye <<< OPERAND_SHIFT;
    end

    logic                    cor_out_valid;
    logic                    out_en;
    logic signed [ANG_W-1:0] cor_angle [0:1];
    logic        [MAG_W-1:0] cor_mag;

    amp_cordic #(
        .CW     (CW),
        .STAGES (CORDIC_STAGES),
        .SBW    (MAG_W)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (isq_out_valid),
        .in_ready  (cor_in_ready),
        .vec_x     (op_x),
        .vec_y     (op_y),
        .sb_in     (mag_next),
        .out_valid (cor_out_valid),
        .out_ready (out_en),
        .angle     (cor_angle),
        .sb_out    (cor_mag)
    );

    // output register with the angle clamps
    logic                      out_valid_reg;
    logic        [MAG_W-1:0]   mag_reg;
    logic signed [PITCH_W-1:0] pitch_reg;
    logic signed [ROLL_W-1:0]  roll_reg;
    logic signed [ANG_W-1:0]   pitch_clamp, roll_clamp;

    assign out_en = !out_valid_reg || result.ready;

    always_comb
    begin
        pitch_clamp = cor_angle[0];
        if (cor_angle[0] > PITCH_LIM)
            pitch_clamp = PITCH_LIM;
        else if (cor_angle[0] < -PITCH_LIM)
            pitch_clamp = -PITCH_LIM;

        // a half turn either way reads as +1800
        roll_clamp = cor_angle[1];
        if (cor_angle[1] > ROLL_LIM || cor_angle[1] <= -ROLL_LIM)
            roll_clamp = ROLL_LIM;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_en)
            out_valid_reg <= cor_out_valid;
    end

    always_ff @(posedge clk)
    begin
        if (out_en)
        begin
            mag_reg   <= cor_mag;
            pitch_reg <= pitch_clamp[PITCH_W-1:0];
            roll_reg  <= roll_clamp[ROLL_W-1:0];
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.magnitude_mg  = mag_reg;
    assign result.pitch_decideg = pitch_reg;
    assign result.roll_decideg  = roll_reg;

`ifndef SYNTHESIS
    // input back-pressure only when the output beat is waiting
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        !sample.ready |-> (result.valid && !result.ready))
        else $error("input stalled with output free");

    a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.pitch_decideg <= $signed(11'sd900)
                          && result.pitch_decideg >= $signed(-11'sd900)))
        else $error("pitch out of range");

    a_roll_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.roll_decideg <= $signed(12'sd1800)
                          && result.roll_decideg > $signed(-12'sd1800)))
        else $error("roll out of range");

    a_front_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && !isq_in_ready) |=> (v3_reg && $stable(mag_rad_reg)))
        else $error("front stage lost a stalled beat");
`endif

endmodule

`default_nettype wire
